// ===== rtl/deq_pkg.sv =====
// deq_pkg: shared types and constants for the double-ended queue unit.
// No dependencies; compiled first.
package deq_pkg;

  localparam int DEQ_DEPTH = 32;
  localparam int DATA_W    = 32;
  localparam int OCC_W     = 6;
  localparam int CAP_W     = 6;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } deq_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } deq_status_t;

  typedef enum logic {
    CFG_IDX_CAPACITY = 1'b0
  } deq_cfg_idx_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shr;      // push front: every cell takes its left neighbor
    logic shl;      // pop front: every cell takes its right neighbor
    logic wr_rear;  // push rear: the cell at the current count loads the word
  } deq_cell_ctrl_t;

endpackage

// ===== rtl/deq_if.sv =====
// deq_in_if / deq_out_if: valid/ready channels for requests and results.
// Depends on deq_pkg.
interface deq_in_if;
  import deq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [DATA_W-1:0] value_in;

  modport source (output valid, kind, value_in, input ready);
  modport sink   (input valid, kind, value_in, output ready);
endinterface

interface deq_out_if;
  import deq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] value_out;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, status, value_out, occupancy, input ready);
  modport sink   (input valid, status, value_out, occupancy, output ready);
endinterface

// ===== rtl/deq_cfg.sv =====
// deq_cfg: APB-style register file holding the capacity register.
// Depends on deq_pkg.
module deq_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [deq_pkg::CFG_AW-1:0]    paddr,
  input  logic [deq_pkg::CFG_DW-1:0]    pwdata,
  output logic [deq_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output logic [deq_pkg::CAP_W-1:0]     cap_o
);
  import deq_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             idx_cap;

  assign pready  = 1'b1;
  assign idx_cap = (paddr[CFG_AW-1] == CFG_IDX_CAPACITY);
  assign cap_o   = cap_r;
  assign prdata  = idx_cap ? CFG_DW'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && idx_cap) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

endmodule

// ===== rtl/deq_cell.sv =====
// deq_cell: one storage cell of the shifting deque chain.
// Depends on deq_pkg.
module deq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  logic                                 clk,
  input  deq_pkg::deq_cell_ctrl_t              ctrl,
  input  logic [CW-1:0]                        count,
  input  logic signed [deq_pkg::DATA_W-1:0]    wr_data,
  input  logic signed [deq_pkg::DATA_W-1:0]    left_data,
  input  logic signed [deq_pkg::DATA_W-1:0]    right_data,
  output logic signed [deq_pkg::DATA_W-1:0]    data_o,
  output logic signed [deq_pkg::DATA_W-1:0]    tap_o
);
  import deq_pkg::*;

  localparam logic [CW-1:0] MyPos  = CW'(IDX);
  localparam logic [CW-1:0] MyNext = CW'(IDX + 1);

  logic signed [DATA_W-1:0] data_r;

  assign data_o = data_r;
  // rear entry sits at count-1
  assign tap_o  = (count == MyNext) ? data_r : '0;

  always_ff @(posedge clk) begin
    priority if (ctrl.shr) begin
      data_r <= left_data;
    end else if (ctrl.shl) begin
      data_r <= right_data;
    end else if (ctrl.wr_rear && (count == MyPos)) begin
      data_r <= wr_data;
    end else begin
      data_r <= data_r;
    end
  end

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// double_ended_queue_unit: deque of signed 32-bit words in a shifting cell chain.
// Depends on deq_pkg, deq_if, deq_cfg, deq_cell.
//
// Requests arrive on in_ch (kind, value_in); each accepted beat gives exactly
// one result beat on out_ch (status, value_out, occupancy). The front entry
// always sits in cell 0: push front shifts the chain right, pop front shifts
// it left, push rear loads the cell at the current count, pop rear reads the
// cell at count-1 through an AND-OR tap across the chain.
// The result is registered: it appears in the cycle after the request beat.
// Throughput: one request per cycle unless out_ch stalls, set by the single shift/load step of the cells.
// The result register frees in_ch.ready whenever out_ch.ready is high, so a
// new request is taken in the same cycle the previous result leaves.
// While out_ch stalls, the held result stays put and in_ch.ready drops.
// Reset (rst_n low at a clock edge) empties the deque, clears the result
// valid flag and sets capacity_in_use to 32; the APB port writes it at byte
// address 0 (pready is always high).
module double_ended_queue_unit #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  deq_in_if.sink                        in_ch,
  deq_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [deq_pkg::CFG_AW-1:0]    paddr,
  input  logic [deq_pkg::CFG_DW-1:0]    pwdata,
  output logic [deq_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import deq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [CAP_W-1:0]         cap;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     out_valid_r;
  logic [1:0]               status_r, status_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [OCC_W-1:0]         occ_r;
  logic                     accept, full, empty;
  deq_cell_ctrl_t           ctrl;
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic signed [DATA_W-1:0] cell_tap  [DEPTH];
  logic signed [DATA_W-1:0] rear_word;

  deq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == DepthC) || (LW'(count_r) >= LW'(cap));
  assign empty       = (count_r == '0);

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_w, right_w;
      if (i == 0) begin : g_first
        assign left_w = in_ch.value_in;
      end else begin : g_mid
        assign left_w = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_inner
        assign right_w = cell_data[i+1];
      end
      deq_cell #(.IDX(i), .CW(CW)) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count_r),
        .wr_data    (in_ch.value_in),
        .left_data  (left_w),
        .right_data (right_w),
        .data_o     (cell_data[i]),
        .tap_o      (cell_tap[i])
      );
    end
  endgenerate

  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | cell_tap[i];
    end
  end

  always_comb begin
    ctrl       = '0;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    value_nxt  = '0;
    unique case (deq_kind_t'(in_ch.kind))
      KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.shr     = accept && (deq_kind_t'(in_ch.kind) == KIND_PUSH_FRONT);
          ctrl.wr_rear = accept && (deq_kind_t'(in_ch.kind) == KIND_PUSH_REAR);
          count_nxt    = count_r + CW'(1);
        end
      end
      KIND_POP_FRONT, KIND_POP_REAR: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.shl  = accept && (deq_kind_t'(in_ch.kind) == KIND_POP_FRONT);
          value_nxt = (deq_kind_t'(in_ch.kind) == KIND_POP_FRONT) ? cell_data[0]
                                                                  : rear_word;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.value_out = value_r;
  assign out_ch.occupancy = occ_r;

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for double_ended_queue_unit, random and directed deque traffic.
// Depends on deq_pkg, deq_in_if/deq_out_if and the RTL top; a shadow deque predicts every result.
module tb_top;
  import deq_pkg::*;

  localparam int                LIMIT_CYCLES = 200000;
  localparam int                HOLD_CYCLES  = 300;
  localparam int                TAIL_CYCLES  = 8;
  localparam logic [CFG_AW-1:0] CAP_ADDR     = CFG_AW'(4 * CFG_IDX_CAPACITY);
  localparam logic [CFG_AW-1:0] SPARE_ADDR   = CFG_AW'(4);

  typedef struct {
    deq_status_t              status;
    logic signed [DATA_W-1:0] value;
    logic [OCC_W-1:0]         occ;
  } reply_t;

  class deque_tracker;
    logic signed [DATA_W-1:0] slots [DEQ_DEPTH];
    int                       front;
    int                       rear;
    int                       count;
    logic [CAP_W-1:0]         cap;
    reply_t                   replies [$];
    int                       fails;

    function new();
      front = 0;
      rear  = 0;
      count = 0;
      cap   = CAP_RESET;
      fails = 0;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    function void note_request(deq_kind_t k, logic signed [DATA_W-1:0] v);
      reply_t r;
      int     lim;
      lim      = (cap > DEQ_DEPTH) ? DEQ_DEPTH : int'(cap);
      r.status = ST_OK;
      r.value  = '0;
      if (k == KIND_PUSH_FRONT || k == KIND_PUSH_REAR) begin
        if (count >= lim) begin
          r.status = ST_FULL;
        end else if (k == KIND_PUSH_FRONT) begin
          front        = (front == 0) ? DEQ_DEPTH - 1 : front - 1;
          slots[front] = v;
          count++;
        end else begin
          slots[rear] = v;
          rear        = (rear == DEQ_DEPTH - 1) ? 0 : rear + 1;
          count++;
        end
      end else begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else if (k == KIND_POP_FRONT) begin
          r.value = slots[front];
          front   = (front == DEQ_DEPTH - 1) ? 0 : front + 1;
          count--;
        end else begin
          rear    = (rear == 0) ? DEQ_DEPTH - 1 : rear - 1;
          r.value = slots[rear];
          count--;
        end
      end
      r.occ = OCC_W'(count);
      replies.push_back(r);
    endfunction

    function void check_reply(logic [1:0] st, logic signed [DATA_W-1:0] v, logic [OCC_W-1:0] occ);
      reply_t r;
      if (replies.size() == 0) begin
        $error("result beat with no request pending");
        fails++;
        return;
      end
      r = replies.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        fails++;
      end
      if (v !== r.value) begin
        $error("value_out: expected %0d, got %0d", r.value, v);
        fails++;
      end
      if (occ !== r.occ) begin
        $error("occupancy: expected %0d, got %0d", r.occ, occ);
        fails++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  deque_tracker tracker;
  bit           calm;
  bit           hold_req;
  int           cfg_fails;
  int           cycles;

  double_ended_queue_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = KIND_PUSH_FRONT;
    in_ch.value_in = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    cfg_fails      = 0;
    cycles         = 0;
    tracker        = new();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL double_ended_queue_unit");
      $finish;
    end
  end

  // result beat checked before request beat: a result never belongs to a same-edge request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        tracker.check_reply(out_ch.status, out_ch.value_out, out_ch.occupancy);
      if (in_ch.valid && in_ch.ready)
        tracker.note_request(deq_kind_t'(in_ch.kind), in_ch.value_in);
    end
  end

  // result receiver: random stalls, plus one long hold on request
  initial begin
    int   n;
    logic rdy;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n        = HOLD_CYCLES;
        rdy      = 1'b0;
      end else if (!calm && $urandom_range(3) == 0) begin
        n   = $urandom_range(1, 12);
        rdy = 1'b0;
      end else begin
        n   = $urandom_range(1, 24);
        rdy = 1'b1;
      end
      repeat (n) begin
        @(negedge clk);
        out_ch.ready <= rdy;
      end
    end
  end

  task automatic send_item(deq_kind_t k, logic signed [DATA_W-1:0] v);
    int gap;
    if (!calm && $urandom_range(5) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= k;
    in_ch.value_in <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_access(bit wr, logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr && addr == CAP_ADDR)
      tracker.cap = data[CAP_W-1:0];
    if (!wr && addr == CAP_ADDR && prdata !== {{(CFG_DW-CAP_W){1'b0}}, tracker.cap}) begin
      $error("capacity_in_use: expected %0d, got %0d", tracker.cap, prdata);
      cfg_fails++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    apb_access(1'b1, CAP_ADDR, {$urandom} & ~CFG_DW'((1 << CAP_W) - 1) | CFG_DW'(c));
    apb_access(1'b0, CAP_ADDR, '0);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(15))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic deq_kind_t rand_kind(int push_pct);
    if ($urandom_range(99) < push_pct)
      return ($urandom_range(1) == 0) ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
    return ($urandom_range(1) == 0) ? KIND_POP_FRONT : KIND_POP_REAR;
  endfunction

  localparam int NPH = 10;
  int ph_cap  [NPH] = '{32, 32,  1,  2, 33, 63,  0, -1, 32, 32};
  int ph_push [NPH] = '{70, 30, 50, 55, 65, 50, 50, 55, 75, 50};
  int ph_len  [NPH] = '{200, 200, 150, 150, 200, 180, 30, 200, 200, 190};

  initial begin
    int c;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset value, then a write to an unmapped index must not disturb it
    apb_access(1'b0, CAP_ADDR, '0);
    apb_access(1'b1, SPARE_ADDR, $urandom);
    apb_access(1'b0, CAP_ADDR, '0);

    // empty pops, front push wrapping below slot zero, extremes at both ends
    send_item(KIND_POP_FRONT, rand_word());
    send_item(KIND_POP_REAR, rand_word());
    send_item(KIND_PUSH_FRONT, 32'sh7fffffff);
    send_item(KIND_PUSH_FRONT, 32'sh80000000);
    send_item(KIND_PUSH_REAR, 32'sh0);
    send_item(KIND_PUSH_REAR, -32'sd1);
    send_item(KIND_POP_REAR, '0);
    send_item(KIND_POP_FRONT, '1);
    send_item(KIND_POP_FRONT, '0);
    send_item(KIND_POP_REAR, '0);
    send_item(KIND_POP_FRONT, '0);
    send_item(KIND_PUSH_REAR, 32'sh12345678);
    send_item(KIND_PUSH_REAR, -32'sd5);
    drain();

    // capacity dropped below the count: pushes refused until pops make room
    set_capacity(CAP_W'(1));
    send_item(KIND_PUSH_FRONT, rand_word());
    send_item(KIND_POP_FRONT, '0);
    send_item(KIND_PUSH_REAR, rand_word());
    send_item(KIND_POP_REAR, '0);
    send_item(KIND_PUSH_REAR, rand_word());
    drain();

    set_capacity(CAP_W'(0));
    send_item(KIND_PUSH_FRONT, rand_word());
    send_item(KIND_PUSH_REAR, rand_word());
    send_item(KIND_POP_FRONT, '0);
    send_item(KIND_POP_REAR, '0);
    drain();

    for (int p = 0; p < NPH; p++) begin
      c = (ph_cap[p] < 0) ? $urandom_range(63) : ph_cap[p];
      set_capacity(CAP_W'(c));
      if (p == NPH - 2)
        hold_req = 1'b1;
      if (p == NPH - 1)
        calm = 1'b1;
      for (int i = 0; i < ph_len[p]; i++)
        send_item(rand_kind(ph_push[p]), rand_word());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.fails == 0 && cfg_fails == 0 && tracker.pending() == 0) begin
      $display("PASS double_ended_queue_unit");
    end else begin
      $display("FAIL double_ended_queue_unit");
    end
    $finish;
  end

endmodule

// ===== double_ended_queue_unit.f =====
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_cfg.sv
rtl/deq_cell.sv
rtl/double_ended_queue_unit.sv
verif/tb_top.sv
